/* rtl/core/psml_pkg.sv */
// Shared constants, types and fixed-point helpers for the point-source log-likelihood block.
package psml_pkg;

    localparam int MAP_DIM   = 64;
    localparam int MAX_ATOMS = 64;

    localparam int MAP_SIZE  = MAP_DIM * MAP_DIM;
    localparam int BEAM_SIZE = 4 * MAP_SIZE;
    localparam int MAP_AW    = $clog2(MAP_SIZE);
    localparam int BEAM_AW   = $clog2(BEAM_SIZE);
    localparam int ATOM_AW   = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ATOMS + 1);

    // scaled coordinate: Q0.16 times MAP_DIM, 16 fraction bits
    localparam int SC_W      = 16 + $clog2(MAP_DIM + 1);
    // beam offset coordinate: MAP_DIM + Xn - Xm, 16 fraction bits
    localparam int BD_W      = SC_W + 1;
    localparam logic [BD_W-1:0] BEAM_OFS = BD_W'(MAP_DIM) << 16;

    localparam int FW        = 32;   // f*(1-f), Q0.32
    localparam int MTERM_W   = 34;   // (F*map) >> 14
    localparam int PTERM_W   = 33;   // (G*beam) >> 15
    localparam int PLUS_W    = MTERM_W + CNT_W;
    localparam int MINUS_W   = PTERM_W + 2 * CNT_W;
    localparam int LL_W      = 44;

    localparam logic [1:0] OP_MAP  = 2'd0;
    localparam logic [1:0] OP_BEAM = 2'd1;
    localparam logic [1:0] OP_ATOM = 2'd2;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] f;
    } t_atom;

    function automatic logic [FW-1:0] flux_weight(input logic [15:0] f);
        logic [FW-1:0] a;
        logic [FW-1:0] b;
        a = FW'(f);
        b = FW'(32'h0001_0000) - FW'(f);
        return a * b;
    endfunction

    function automatic logic [SC_W-1:0] scale_coord(input logic [15:0] c);
        return SC_W'(c) * SC_W'(MAP_DIM);
    endfunction

endpackage

/* rtl/core/psml_pair.sv */
// Pair-term pipeline: beam index, flux product and beam-weighted term for one atom pair.
module psml_pair
    import psml_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_atom                i_atom,
    input  logic [SC_W-1:0]      i_sxn,
    input  logic [SC_W-1:0]      i_syn,
    input  logic [FW-1:0]        i_fn,
    output logic [BEAM_AW-1:0]   o_beam_addr,
    input  logic [15:0]          i_beam_data,
    output logic [PTERM_W-1:0]   o_term,
    output logic                 o_term_valid,
    output logic                 o_busy
);

    logic                 r_v2, r_v3, r_v4;
    logic [BEAM_AW-1:0]   r_bidx;
    logic [FW-1:0]        r_fm;
    logic [31:0]          r_g;
    logic [PTERM_W-1:0]   r_term;

    logic [SC_W-1:0]      sxm, sym;
    logic [BD_W-1:0]      dx, dy;
    logic [BEAM_AW-1:0]   n_bidx;
    logic [63:0]          gprod;
    logic [47:0]          tprod;

    always_comb begin
        sxm    = scale_coord(i_atom.x);
        sym    = scale_coord(i_atom.y);
        dx     = BEAM_OFS + BD_W'(i_sxn) - BD_W'(sxm);
        dy     = BEAM_OFS + BD_W'(i_syn) - BD_W'(sym);
        n_bidx = BEAM_AW'(dx[BD_W-1:16])
               + BEAM_AW'(dy[BD_W-1:16]) * BEAM_AW'(2 * MAP_DIM);
        gprod  = 64'(i_fn) * 64'(r_fm);
        tprod  = 48'(r_g) * 48'(i_beam_data);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // beam data for r_bidx arrives in the following cycle, aligned with r_g
    always_ff @(posedge i_clk) begin
        r_bidx <= n_bidx;
        r_fm   <= flux_weight(i_atom.f);
        r_g    <= gprod[63:32];
        r_term <= tprod[47:15];
    end

    assign o_beam_addr  = r_bidx;
    assign o_term       = r_term;
    assign o_term_valid = r_v4;
    assign o_busy       = i_valid | r_v2 | r_v3 | r_v4;

endmodule

/* rtl/core/point_source_map_loglike.sv */
// Top level: table and atom stores, pass sequencer, accumulators and result register.
//
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------------------
//  in      | i_in_valid / o_in_ready   | i_op i_table_addr i_table_value i_atom_x/y/f i_last
//  out     | o_out_valid / i_out_ready | o_log_likelihood o_too_many_atoms
//
// Table writes and atoms are taken one per cycle while no pass runs.
// An atom marked last starts a pass over the N stored atoms: per outer atom, states for
// its read, map read and map term, then the atom store streamed through the pair
// pipeline, then a drain; the atom store has one read port, shared by both reads.
// Reset clears the count, the overflow flag, the sequencer and the output valid; tables
// are not cleared. A stalled result holds in the output register while new items are taken.
module point_source_map_loglike
    import psml_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_op,
    input  logic [13:0]             i_table_addr,
    input  logic [15:0]             i_table_value,
    input  logic [15:0]             i_atom_x,
    input  logic [15:0]             i_atom_y,
    input  logic [15:0]             i_atom_f,
    input  logic                    i_last,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [LL_W-1:0]  o_log_likelihood,
    output logic                    o_too_many_atoms
);

    localparam int DIFF_W = ((PLUS_W > MINUS_W) ? PLUS_W : MINUS_W) + 1;
    localparam int SAT_W  = (DIFF_W > LL_W) ? DIFF_W : LL_W;
    localparam logic signed [SAT_W-1:0] LL_MAX =
        {{(SAT_W-LL_W+1){1'b0}}, {(LL_W-1){1'b1}}};
    localparam logic signed [SAT_W-1:0] LL_MIN =
        {{(SAT_W-LL_W+1){1'b1}}, {(LL_W-1){1'b0}}};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_NRD   = 3'd1;
    localparam logic [2:0] S_NLD   = 3'd2;
    localparam logic [2:0] S_MRD   = 3'd3;
    localparam logic [2:0] S_MACC  = 3'd4;
    localparam logic [2:0] S_PAIR  = 3'd5;
    localparam logic [2:0] S_DRAIN = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [15:0] map_mem  [MAP_SIZE];
    logic [15:0] beam_mem [BEAM_SIZE];
    t_atom       atom_mem [MAX_ATOMS];

    logic [2:0]            r_state;
    logic [CNT_W-1:0]      r_count;
    logic                  r_overflow;
    logic [ATOM_AW-1:0]    r_n, r_m;
    logic                  r_p1_v;
    logic                  r_mt_v;
    logic [PLUS_W-1:0]     r_plus;
    logic [MINUS_W-1:0]    r_minus;
    logic                  r_out_valid;
    logic [LL_W-1:0]       r_ll;
    logic                  r_too_many;

    t_atom                 r_atom_q;
    logic [15:0]           r_map_q;
    logic [15:0]           r_beam_q;
    logic [SC_W-1:0]       r_sxn, r_syn;
    logic [FW-1:0]         r_fn;
    logic [MAP_AW-1:0]     r_midx;
    logic [MTERM_W-1:0]    r_mterm;

    logic                  accept;
    logic                  out_free;
    logic [ATOM_AW-1:0]    last_idx;
    logic [ATOM_AW-1:0]    rd_addr;
    logic [SC_W-1:0]       sx_now, sy_now;
    logic [MAP_AW-1:0]     n_midx;
    logic [47:0]           mprod;
    logic signed [SAT_W-1:0] diff;
    logic [LL_W-1:0]       n_ll;
    logic                  map_we, beam_we, atom_we;

    logic [BEAM_AW-1:0]    beam_addr;
    logic [PTERM_W-1:0]    pair_term;
    logic                  pair_term_v;
    logic                  pair_busy;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign last_idx    = ATOM_AW'(r_count - CNT_W'(1));
    assign rd_addr     = (r_state == S_PAIR) ? r_m : r_n;

    assign map_we  = accept && (i_op == OP_MAP)
                   && (32'(i_table_addr) < 32'(MAP_SIZE));
    assign beam_we = accept && (i_op == OP_BEAM)
                   && (32'(i_table_addr) < 32'(BEAM_SIZE));
    assign atom_we = accept && (i_op == OP_ATOM) && (r_count < CNT_W'(MAX_ATOMS));

    always_comb begin
        sx_now = scale_coord(r_atom_q.x);
        sy_now = scale_coord(r_atom_q.y);
        n_midx = MAP_AW'(sx_now[SC_W-1:16])
               + MAP_AW'(sy_now[SC_W-1:16]) * MAP_AW'(MAP_DIM);
        mprod  = 48'(r_fn) * 48'(r_map_q);
        diff   = $signed(SAT_W'(r_plus)) - $signed(SAT_W'(r_minus));
        if (diff > LL_MAX) begin
            n_ll = LL_MAX[LL_W-1:0];
        end else if (diff < LL_MIN) begin
            n_ll = LL_MIN[LL_W-1:0];
        end else begin
            n_ll = diff[LL_W-1:0];
        end
    end

    // memories: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            map_mem[MAP_AW'(i_table_addr)] <= i_table_value;
        end
        r_map_q <= map_mem[r_midx];
    end

    always_ff @(posedge i_clk) begin
        if (beam_we) begin
            beam_mem[BEAM_AW'(i_table_addr)] <= i_table_value;
        end
        r_beam_q <= beam_mem[beam_addr];
    end

    always_ff @(posedge i_clk) begin
        if (atom_we) begin
            atom_mem[r_count[ATOM_AW-1:0]] <= '{x: i_atom_x, y: i_atom_y, f: i_atom_f};
        end
        r_atom_q <= atom_mem[rd_addr];
    end

    // outer-atom registers, held for the whole pair stream
    always_ff @(posedge i_clk) begin
        if (r_state == S_NLD) begin
            r_sxn  <= sx_now;
            r_syn  <= sy_now;
            r_fn   <= flux_weight(r_atom_q.f);
            r_midx <= n_midx;
        end
        if (r_state == S_MACC) begin
            r_mterm <= mprod[47:14];
        end
        // load the result only when the output register is free
        if ((r_state == S_FIN) && out_free) begin
            r_ll       <= n_ll;
            r_too_many <= r_overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_n         <= '0;
            r_m         <= '0;
            r_p1_v      <= 1'b0;
            r_mt_v      <= 1'b0;
            r_plus      <= '0;
            r_minus     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_p1_v <= (r_state == S_PAIR);
            r_mt_v <= (r_state == S_MACC);
            if (r_mt_v) begin
                r_plus <= r_plus + PLUS_W'(r_mterm);
            end
            if (pair_term_v) begin
                r_minus <= r_minus + MINUS_W'(pair_term);
            end
            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept && (i_op == OP_ATOM)) begin
                        if (atom_we) begin
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_overflow <= 1'b1;
                        end
                        if (i_last) begin
                            r_n     <= '0;
                            r_plus  <= '0;
                            r_minus <= '0;
                            r_state <= S_NRD;
                        end
                    end
                end
                S_NRD:  r_state <= S_NLD;
                S_NLD:  r_state <= S_MRD;
                S_MRD:  r_state <= S_MACC;
                S_MACC: begin
                    r_m     <= '0;
                    r_state <= S_PAIR;
                end
                S_PAIR: begin
                    r_m <= r_m + ATOM_AW'(1);
                    if (r_m == last_idx) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // wait for the pair pipeline to empty before the next outer atom
                    if (!pair_busy) begin
                        if (r_n == last_idx) begin
                            r_state <= S_FIN;
                        end else begin
                            r_n     <= r_n + ATOM_AW'(1);
                            r_state <= S_NRD;
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_count     <= '0;
                        r_overflow  <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    psml_pair u_pair (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_p1_v),
        .i_atom       (r_atom_q),
        .i_sxn        (r_sxn),
        .i_syn        (r_syn),
        .i_fn         (r_fn),
        .o_beam_addr  (beam_addr),
        .i_beam_data  (r_beam_q),
        .o_term       (pair_term),
        .o_term_valid (pair_term_v),
        .o_busy       (pair_busy)
    );

    assign o_out_valid      = r_out_valid;
    assign o_log_likelihood = $signed(r_ll);
    assign o_too_many_atoms = r_too_many;

endmodule
